### rtl/tmq_pkg.sv
// ----------------------------------------------------------------------------
// tmq_pkg
// Shared types and constants of the tagged receive match queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tmq_pkg;

  localparam int unsigned TAG_W    = 64;
  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned HDL_IO_W = 16;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned LIMIT_W  = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W    = 64;

  // result status codes
  localparam logic [STAT_W-1:0] ST_POSTED  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_MATCHED = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOMATCH = 2'd3;

  // item modes
  localparam logic MODE_POST  = 1'b0;
  localparam logic MODE_MATCH = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WILDCARD    = 2'd1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET    = 7'd64;

  // one word as held between front and back
  typedef struct packed {
    logic                is_match;
    logic [TAG_W-1:0]    tag;
    logic [TAG_W-1:0]    ignore_mask;
    logic [ADDR_W-1:0]   peer_addr;
    logic [HDL_IO_W-1:0] entry_handle;
  } tmq_item_t;

  // front to back control
  typedef struct packed {
    logic valid;
  } tmq_fctl_t;

  // back to front control
  typedef struct packed {
    logic pop;
  } tmq_bctl_t;

endpackage

`default_nettype wire

### rtl/tmq_if.sv
// ----------------------------------------------------------------------------
// tmq_in_if / tmq_out_if
// Valid/ready channels carrying input words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface tmq_in_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [tmq_pkg::TAG_W-1:0]    tag;
  logic [tmq_pkg::TAG_W-1:0]    ignore_mask;
  logic [tmq_pkg::ADDR_W-1:0]   peer_addr;
  logic [tmq_pkg::HDL_IO_W-1:0] entry_handle;

  modport source (output valid, mode, tag, ignore_mask, peer_addr, entry_handle,
                  input ready);
  modport sink   (input valid, mode, tag, ignore_mask, peer_addr, entry_handle,
                  output ready);
endinterface

interface tmq_out_if;
  logic                         valid;
  logic                         ready;
  logic [tmq_pkg::STAT_W-1:0]   status;
  logic [tmq_pkg::HDL_IO_W-1:0] matched_handle;

  modport source (output valid, status, matched_handle, input ready);
  modport sink   (input valid, status, matched_handle, output ready);
endinterface

`default_nettype wire

### rtl/tmq_front.sv
// ----------------------------------------------------------------------------
// tmq_front
// Accepts input words, classifies them and holds them in a two-word queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tmq_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  tmq_in_if.sink                  in_item,
  output tmq_pkg::tmq_item_t      head,
  output tmq_pkg::tmq_fctl_t      fctl,
  input  tmq_pkg::tmq_bctl_t      bctl
);
  import tmq_pkg::*;

  tmq_item_t  q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push, pop;
  tmq_item_t  in_word;

  // classify the incoming word
  always_comb begin
    in_word.is_match     = (in_item.mode == MODE_MATCH);
    in_word.tag          = in_item.tag;
    in_word.ignore_mask  = in_item.ignore_mask;
    in_word.peer_addr    = in_item.peer_addr;
    in_word.entry_handle = in_item.entry_handle;
  end

  assign in_item.ready = (cnt_r != 2'd2);
  assign push = in_item.valid && in_item.ready;
  assign pop  = bctl.pop && (cnt_r != 2'd0);

  // store payload
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_word;
    end
  end

  // advance pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  assign head       = q_r[rd_ptr_r];
  assign fctl.valid = (cnt_r != 2'd0);

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("front queue fill out of range");
  a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !pop) |=> cnt_r == 2'd2) else $error("full queue lost a word");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> cnt_r == $past(cnt_r) - 2'd1) else $error("pop count slip");

endmodule

`default_nettype wire

### rtl/tmq_back.sv
// ----------------------------------------------------------------------------
// tmq_back
// Holds the ordered entry queue, matches all entries in parallel, removes
// the first hit with compaction and registers the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module tmq_back #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  tmq_pkg::tmq_item_t                head,
  input  tmq_pkg::tmq_fctl_t                fctl,
  output tmq_pkg::tmq_bctl_t                bctl,
  input  wire logic [tmq_pkg::LIMIT_W-1:0]  queue_limit,
  input  wire logic [tmq_pkg::ADDR_W-1:0]   wildcard_addr,
  tmq_out_if.source                         out_res
);
  import tmq_pkg::*;

  localparam int unsigned CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam int unsigned XW   = HANDLE_BITS + HDL_IO_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DONE = 1'b1;

  logic [TAG_W-1:0]       tag_r  [QUEUE_DEPTH];
  logic [TAG_W-1:0]       mask_r [QUEUE_DEPTH];
  logic [ADDR_W-1:0]      addr_r [QUEUE_DEPTH];
  logic [HANDLE_BITS-1:0] hdl_r  [QUEUE_DEPTH];
  logic [CW-1:0]          count_r;
  logic                   state_r;
  tmq_item_t              item_r;
  logic [QUEUE_DEPTH-1:0] hit_r;
  logic                   out_valid_r;
  logic [STAT_W-1:0]      status_r;
  logic [HDL_IO_W-1:0]    handle_out_r;

  logic [QUEUE_DEPTH-1:0] hit_nxt, first_hit, shift_sel;
  logic [HANDLE_BITS-1:0] hit_handle;
  logic [XW-1:0]          hdl_in_ext, hdl_out_ext;
  logic [HANDLE_BITS-1:0] hdl_in;
  logic                   full, commit, take;
  logic [CMPW-1:0]        cnt_cmp, lim_cmp, depth_cmp;

  // compare head against every live entry
  always_comb begin
    for (int j = 0; j < QUEUE_DEPTH; j++) begin
      hit_nxt[j] = (CW'(j) < count_r) &&
                   (((tag_r[j] ^ head.tag) & ~mask_r[j]) == '0) &&
                   (addr_r[j] == wildcard_addr || head.peer_addr == wildcard_addr ||
                    addr_r[j] == head.peer_addr);
    end
  end

  // pick oldest hit and mark entries from it upward
  assign first_hit = hit_r & (~hit_r + QUEUE_DEPTH'(1));
  assign shift_sel = (first_hit == '0) ? '0 : ~(first_hit - QUEUE_DEPTH'(1));

  always_comb begin
    hit_handle = '0;
    for (int j = 0; j < QUEUE_DEPTH; j++) begin
      hit_handle = hit_handle | (first_hit[j] ? hdl_r[j] : '0);
    end
  end

  assign hdl_in_ext  = {{HANDLE_BITS{1'b0}}, item_r.entry_handle};
  assign hdl_in      = hdl_in_ext[HANDLE_BITS-1:0];
  assign hdl_out_ext = {{HDL_IO_W{1'b0}}, hit_handle};

  assign cnt_cmp   = CMPW'(count_r);
  assign lim_cmp   = CMPW'(queue_limit);
  assign depth_cmp = CMPW'(QUEUE_DEPTH);
  assign full      = (cnt_cmp >= lim_cmp) || (cnt_cmp >= depth_cmp);

  assign take   = (state_r == S_IDLE) && fctl.valid;
  assign commit = (state_r == S_DONE) && (!out_valid_r || out_res.ready);
  assign bctl.pop = take;

  // sequence one word at a time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE:  if (take)   state_r <= S_DONE;
        S_DONE:  if (commit) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= head;
      hit_r  <= hit_nxt;
    end
  end

  // append on post when not full, close up on removal
  always_ff @(posedge clk) begin
    if (commit) begin
      for (int j = 0; j < QUEUE_DEPTH; j++) begin
        if (!item_r.is_match) begin
          if (!full && CW'(j) == count_r) begin
            tag_r[j]  <= item_r.tag;
            mask_r[j] <= item_r.ignore_mask;
            addr_r[j] <= item_r.peer_addr;
            hdl_r[j]  <= hdl_in;
          end
        end else if (shift_sel[j] && j + 1 < QUEUE_DEPTH) begin
          tag_r[j]  <= tag_r[(j + 1) % QUEUE_DEPTH];
          mask_r[j] <= mask_r[(j + 1) % QUEUE_DEPTH];
          addr_r[j] <= addr_r[(j + 1) % QUEUE_DEPTH];
          hdl_r[j]  <= hdl_r[(j + 1) % QUEUE_DEPTH];
        end
      end
    end
  end

  // track entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (commit) begin
      if (!item_r.is_match && !full)              count_r <= count_r + CW'(1);
      else if (item_r.is_match && first_hit != '0) count_r <= count_r - CW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      if (!item_r.is_match) begin
        status_r     <= full ? ST_FULL : ST_POSTED;
        handle_out_r <= '0;
      end else if (first_hit != '0) begin
        status_r     <= ST_MATCHED;
        handle_out_r <= hdl_out_ext[HDL_IO_W-1:0];
      end else begin
        status_r     <= ST_NOMATCH;
        handle_out_r <= '0;
      end
    end
  end

  assign out_res.valid          = out_valid_r;
  assign out_res.status         = status_r;
  assign out_res.matched_handle = handle_out_r;

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    CMPW'(count_r) <= depth_cmp) else $error("entry count above depth");
  a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(first_hit)) else $error("more than one first hit");
  a_match_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && item_r.is_match && first_hit != '0) |=> count_r == $past(count_r) - CW'(1))
    else $error("removal did not drop count");
  a_hit_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> ((first_hit & ~shift_sel) == '0)) else $error("hit mask slip");

endmodule

`default_nettype wire

### rtl/tagged_receive_match_queue_core.sv
// ----------------------------------------------------------------------------
// tagged_receive_match_queue_core
// Posted-receive queue with masked tag and wildcard address matching.
// ----------------------------------------------------------------------------
// Usage:
//   in_item  : valid/ready words. mode 0 posts an entry (tag, ignore_mask,
//              peer_addr, entry_handle); mode 1 matches an arriving message.
//   out_res  : one result word per input word, in order: status (posted,
//              full, matched, no match) and the removed entry's handle.
//   cfg_*    : write port; index 0 queue_limit, index 1 wildcard_addr.
//              Write only while the block is idle.
// Timing: a word sits in a two-word front queue, then the back unit takes
//   it in S_IDLE, compares all entries in parallel in that cycle and, in
//   S_DONE once the result register is free, commits the append or removal
//   with compaction and registers the result word. The back unit takes no
//   new word until it has committed the last one.
// Reset: entry count cleared, limit 64, wildcard all ones; entry contents
//   are not cleared. A stalled receiver holds the result word; one more word
//   waits in the back unit and two more queue in front before in_item.ready
//   drops.
// ----------------------------------------------------------------------------
`default_nettype none

module tagged_receive_match_queue_core #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  tmq_in_if.sink                              in_item,
  tmq_out_if.source                           out_res,
  input  wire logic                           cfg_we,
  input  wire logic [tmq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tmq_pkg::CFG_W-1:0]      cfg_wdata
);
  import tmq_pkg::*;

  logic [LIMIT_W-1:0] queue_limit_r;
  logic [ADDR_W-1:0]  wildcard_r;
  tmq_item_t          head;
  tmq_fctl_t          fctl;
  tmq_bctl_t          bctl;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queue_limit_r <= LIMIT_RESET;
      wildcard_r    <= '1;
    end else if (cfg_we) begin
      if (cfg_index == CFG_QUEUE_LIMIT) queue_limit_r <= cfg_wdata[LIMIT_W-1:0];
      else if (cfg_index == CFG_WILDCARD) wildcard_r  <= cfg_wdata;
    end
  end

  tmq_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_item),
    .head    (head),
    .fctl    (fctl),
    .bctl    (bctl)
  );

  tmq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .fctl          (fctl),
    .bctl          (bctl),
    .queue_limit   (queue_limit_r),
    .wildcard_addr (wildcard_r),
    .out_res       (out_res)
  );

endmodule

`default_nettype wire
